/* sv/http_chunked_body_decoder_unit_assert.svh */
// Assertion macros used by the HTTP chunked body decoder RTL.
// Included by hcbd_back, the module that carries concurrent assertions; no other dependencies.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define HCBD_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("hcbd assertion failed");
`define HCBD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("hcbd implication failed");
`else
`define HCBD_ASSERT(lbl, ck, rn, prop)
`define HCBD_ASSERT_IMP(lbl, ck, rn, ante, cons)
`endif
`endif

/* sv/hcbd_pkg.sv */
// Types and constants shared by the HTTP chunked body decoder modules.
// No dependencies.
`timescale 1ns / 1ps
package hcbd_pkg;
    localparam logic [1:0] PH_SIZE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_CRLF = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [1:0] EV_ABSORB = 2'd0;
    localparam logic [1:0] EV_DATA   = 2'd1;
    localparam logic [1:0] EV_END    = 2'd2;
    localparam logic [1:0] EV_ERROR  = 2'd3;

    localparam logic [1:0] CP_FIRST = 2'd0;
    localparam logic [1:0] CP_CR_OK = 2'd1;
    localparam logic [1:0] CP_BAD   = 2'd2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic [7:0] raw;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } hcbd_item_t;
endpackage

/* sv/hcbd_front.sv */
// Front stage: accepts raw body bytes and classifies them for the back end.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps
module hcbd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    output logic                item_valid,
    input  logic                item_ready,
    output hcbd_pkg::hcbd_item_t item
);
    import hcbd_pkg::*;

    logic       valid_reg;
    hcbd_item_t item_reg;
    hcbd_item_t item_next;

    always_comb
    begin
        item_next.raw    = in_byte;
        item_next.is_cr  = (in_byte == CH_CR);
        item_next.is_lf  = (in_byte == CH_LF);
        item_next.is_hex = 1'b1;
        item_next.hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            item_next.hex_val = 4'(in_byte - 8'h30);
        end
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
        begin
            item_next.hex_val = 4'(in_byte - 8'h37);
        end
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
        begin
            item_next.hex_val = 4'(in_byte - 8'h57);
        end
        else
        begin
            item_next.is_hex = 1'b0;
        end
    end

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end
endmodule

/* sv/hcbd_queue.sv */
// Two-entry queue of classified bytes between the front and back ends.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps
module hcbd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  hcbd_pkg::hcbd_item_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output hcbd_pkg::hcbd_item_t pop_item
);
    import hcbd_pkg::*;

    hcbd_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

/* sv/hcbd_back.sv */
// Back end: chunked framing state machine with a registered result output.
// Depends on hcbd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_unit_assert.svh"
module hcbd_back #(
    parameter int SIZE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  hcbd_pkg::hcbd_item_t item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_event,
    output logic [7:0]          out_data,
    output logic                out_last
);
    import hcbd_pkg::*;

    logic [1:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] remaining_reg, remaining_next;
    logic                 seen_reg, seen_next;
    logic                 closed_reg, closed_next;
    logic                 has_chars_reg, has_chars_next;
    logic                 ovf_reg, ovf_next;
    logic                 pending_cr_reg, pending_cr_next;
    logic [1:0]           crlf_reg, crlf_next;
    logic                 out_valid_reg;
    logic [1:0]           out_event_reg, out_event_next;
    logic [7:0]           out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic                 take;
    logic                 closed_eff;
    logic                 has_eff;
    logic                 bad_line;
    logic [SIZE_BITS-1:0] rem_dec;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;
    assign closed_eff = closed_reg || pending_cr_reg;
    assign has_eff    = has_chars_reg || pending_cr_reg;
    assign bad_line   = !has_chars_reg || !seen_reg || ovf_reg;
    assign rem_dec    = remaining_reg - SIZE_BITS'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        remaining_next  = remaining_reg;
        seen_next       = seen_reg;
        closed_next     = closed_reg;
        has_chars_next  = has_chars_reg;
        ovf_next        = ovf_reg;
        pending_cr_next = pending_cr_reg;
        crlf_next       = crlf_reg;
        out_event_next  = EV_ABSORB;
        out_data_next   = 8'd0;
        out_last_next   = 1'b0;
        case (phase_reg)
            PH_SIZE:
            begin
                if (pending_cr_reg && item.is_lf)
                begin
                    seen_next       = 1'b0;
                    closed_next     = 1'b0;
                    has_chars_next  = 1'b0;
                    ovf_next        = 1'b0;
                    pending_cr_next = 1'b0;
                    if (bad_line)
                    begin
                        out_event_next = EV_ERROR;
                        remaining_next = '0;
                    end
                    else if (remaining_reg == '0)
                    begin
                        out_event_next = EV_END;
                        phase_next     = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                else if (item.is_cr)
                begin
                    pending_cr_next = 1'b1;
                    closed_next     = closed_eff;
                    has_chars_next  = has_eff;
                end
                else
                begin
                    pending_cr_next = 1'b0;
                    has_chars_next  = 1'b1;
                    if (closed_eff)
                    begin
                        closed_next = 1'b1;
                    end
                    else if (item.is_hex)
                    begin
                        seen_next = 1'b1;
                        if (remaining_reg[SIZE_BITS-1:SIZE_BITS-4] != 4'd0)
                        begin
                            ovf_next = 1'b1;
                        end
                        remaining_next = {remaining_reg[SIZE_BITS-5:0], item.hex_val};
                    end
                    else
                    begin
                        closed_next = 1'b1;
                    end
                end
            end
            PH_DATA:
            begin
                out_event_next = EV_DATA;
                out_data_next  = item.raw;
                remaining_next = rem_dec;
                if (rem_dec == '0)
                begin
                    out_last_next = 1'b1;
                    phase_next    = PH_CRLF;
                    crlf_next     = CP_FIRST;
                end
            end
            PH_CRLF:
            begin
                if (crlf_reg == CP_FIRST)
                begin
                    crlf_next = item.is_cr ? CP_CR_OK : CP_BAD;
                end
                else
                begin
                    if (crlf_reg == CP_CR_OK && item.is_lf)
                    begin
                        phase_next      = PH_SIZE;
                        remaining_next  = '0;
                        seen_next       = 1'b0;
                        closed_next     = 1'b0;
                        has_chars_next  = 1'b0;
                        ovf_next        = 1'b0;
                        pending_cr_next = 1'b0;
                    end
                    else
                    begin
                        out_event_next = EV_ERROR;
                    end
                    crlf_next = CP_FIRST;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            remaining_reg  <= '0;
            seen_reg       <= 1'b0;
            closed_reg     <= 1'b0;
            has_chars_reg  <= 1'b0;
            ovf_reg        <= 1'b0;
            pending_cr_reg <= 1'b0;
            crlf_reg       <= CP_FIRST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg      <= phase_next;
                remaining_reg  <= remaining_next;
                seen_reg       <= seen_next;
                closed_reg     <= closed_next;
                has_chars_reg  <= has_chars_next;
                ovf_reg        <= ovf_next;
                pending_cr_reg <= pending_cr_next;
                crlf_reg       <= crlf_next;
            end
            if (item_ready)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_event_reg <= out_event_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    `HCBD_ASSERT(done_is_final, clk, rst_n, phase_reg == PH_DONE |=> phase_reg == PH_DONE)
    `HCBD_ASSERT_IMP(data_has_bytes, clk, rst_n, phase_reg == PH_DATA, remaining_reg != '0)
    `HCBD_ASSERT_IMP(last_is_data, clk, rst_n, out_valid_reg && out_last_reg,
                     out_event_reg == EV_DATA)
    `HCBD_ASSERT_IMP(crlf_code_ok, clk, rst_n, phase_reg == PH_CRLF, crlf_reg != 2'd3)
endmodule

/* sv/http_chunked_body_decoder_unit.sv */
// HTTP/1.1 chunked body decoder: one raw body byte in, one result out per byte.
// The result reaches the output through the classify register, the two-entry queue and
// the output register of the framing state machine.
// Throughput is one byte per cycle while the output is not stalled.
// Reset (rst_n low, asynchronous) empties all stages and starts in the size line.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue and hcbd_back.
`timescale 1ns / 1ps
module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] m_axis_tuser,   // [1:0] event_res
    output logic       m_axis_tlast
);
    import hcbd_pkg::*;

    logic       f_valid;
    logic       f_ready;
    hcbd_item_t f_item;
    logic       q_valid;
    logic       q_ready;
    hcbd_item_t q_item;

    hcbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    hcbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_event  (m_axis_tuser),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );
endmodule

/* test/http_chunked_body_decoder_unit_tb.sv */
// Self-checking testbench for http_chunked_body_decoder_unit: a stream of chunked body bytes is
// decoded by a local state machine and every output transfer is checked field by field.
// Depends on hcbd_pkg and the decoder RTL.
`timescale 1ns / 1ps
module http_chunked_body_decoder_unit_tb;
    import hcbd_pkg::*;

    localparam int SIZE_W = 32;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_BYTES = 185;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_NOT_HEX = 8'h67;

    typedef enum logic [1:0]
    {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [1:0]        phase;
        logic [SIZE_W-1:0] remaining;
        logic              digits_seen;
        logic              digits_closed;
        logic              line_has_chars;
        logic              size_overflow;
        logic              pending_cr;
        logic [1:0]        crlf_progress;
    } chunk_state_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] data_byte;
        logic       chunk_last;
    } decoded_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    logic [7:0]   pending_bytes[$];
    decoded_t     expected_results[$];
    chunk_state_t decoder_now = '0;
    chunk_state_t plan_state = '0;
    idle_mode_t   idle_mode = IDLE_NONE;
    logic         hold_sender = 1'b0;
    logic         in_taken = 1'b0;
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    int           planned_count = 0;

    http_chunked_body_decoder_unit #(
        .SIZE_BITS(SIZE_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            return {1'b1, c[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        string s;
        s = $sformatf("%h", v);
        if (s[0] >= "a" && $urandom_range(0, 1) == 1)
            return s[0] - 8'h20;
        return s[0];
    endfunction

    function automatic chunk_state_t line_cleared(input chunk_state_t st);
        st.digits_seen = 1'b0;
        st.digits_closed = 1'b0;
        st.line_has_chars = 1'b0;
        st.size_overflow = 1'b0;
        st.pending_cr = 1'b0;
        return st;
    endfunction

    function automatic logic sender_idles();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 66;
            IDLE_BOTH: return $urandom_range(0, 99) < 6;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(0, 99) < 66;
            IDLE_BOTH: return $urandom_range(0, 99) < 6;
            default:   return 1'b0;
        endcase
    endfunction

    // The digit run ends at the first byte that is not a hex digit, a semicolon included.
    task automatic take_line_char(inout chunk_state_t st, input logic [7:0] c);
        logic [4:0] h;
        h = (c == CH_SEMI) ? 5'd0 : hex_digit(c);
        st.line_has_chars = 1'b1;
        if (!st.digits_closed)
        begin
            if (!h[4])
                st.digits_closed = 1'b1;
            else
            begin
                st.digits_seen = 1'b1;
                if (st.remaining[SIZE_W-1 -: 4] != 4'd0)
                    st.size_overflow = 1'b1;
                st.remaining = {st.remaining[SIZE_W-5:0], h[3:0]};
            end
        end
    endtask

    task automatic decode_byte(inout chunk_state_t st, input logic [7:0] b, output decoded_t r);
        logic bad;
        r = '0;
        r.event_res = EV_ABSORB;
        case (st.phase)
            PH_SIZE:
            begin
                if (st.pending_cr && b == CH_LF)
                begin
                    bad = !st.line_has_chars || !st.digits_seen || st.size_overflow;
                    st = line_cleared(st);
                    if (bad)
                    begin
                        r.event_res = EV_ERROR;
                        st.remaining = '0;
                    end
                    else if (st.remaining == '0)
                    begin
                        r.event_res = EV_END;
                        st.phase = PH_DONE;
                    end
                    else
                        st.phase = PH_DATA;
                end
                else
                begin
                    if (st.pending_cr)
                    begin
                        take_line_char(st, CH_CR);
                        st.pending_cr = 1'b0;
                    end
                    if (b == CH_CR)
                        st.pending_cr = 1'b1;
                    else
                        take_line_char(st, b);
                end
            end
            PH_DATA:
            begin
                r.event_res = EV_DATA;
                r.data_byte = b;
                st.remaining = st.remaining - 1'b1;
                if (st.remaining == '0)
                begin
                    r.chunk_last = 1'b1;
                    st.phase = PH_CRLF;
                    st.crlf_progress = CP_FIRST;
                end
            end
            PH_CRLF:
            begin
                if (st.crlf_progress == CP_FIRST)
                    st.crlf_progress = (b == CH_CR) ? CP_CR_OK : CP_BAD;
                else
                begin
                    if (st.crlf_progress == CP_CR_OK && b == CH_LF)
                    begin
                        st.phase = PH_SIZE;
                        st.remaining = '0;
                        st = line_cleared(st);
                    end
                    else
                        r.event_res = EV_ERROR;
                    st.crlf_progress = CP_FIRST;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic plan_byte(input logic [7:0] b);
        decoded_t unused;
        pending_bytes.push_back(b);
        decode_byte(plan_state, b, unused);
        planned_count++;
    endtask

    task automatic plan_line(input string body);
        foreach (body[i])
            plan_byte(body[i]);
        plan_byte(CH_CR);
        plan_byte(CH_LF);
    endtask

    task automatic plan_chunk();
        int size;
        string digits;
        logic [7:0] c;
        logic [7:0] t0;
        logic [7:0] t1;
        size = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 16) : $urandom_range(17, 300);
        digits = $sformatf("%0h", size);
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0)
            plan_byte("0");
        foreach (digits[i])
        begin
            c = digits[i];
            if (c >= "a" && $urandom_range(0, 1) == 1)
                c = c - 8'h20;
            plan_byte(c);
        end
        case ($urandom_range(0, 5))
            0:
            begin
                plan_byte(CH_SEMI);
                repeat ($urandom_range(0, 4))
                    plan_byte(8'($urandom_range(8'h20, 8'h7E)));
            end
            1:
            begin
                // Any byte that is not a hex digit closes the run, a lone CR as well.
                c = 8'($urandom_range(0, 255));
                if (hex_digit(c) >= 5'd16)
                    c = CH_NOT_HEX;
                plan_byte(c);
                repeat ($urandom_range(0, 4))
                    plan_byte(8'($urandom_range(8'h20, 8'h7E)));
            end
            default:
            begin
            end
        endcase
        plan_byte(CH_CR);
        plan_byte(CH_LF);
        repeat (size)
            plan_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
        begin
            t0 = ($urandom_range(0, 1) == 1) ? CH_CR : 8'($urandom_range(0, 255));
            t1 = 8'($urandom_range(0, 255));
            if (t0 == CH_CR && t1 == CH_LF)
                t1 = 8'h00;
            plan_byte(t0);
            plan_byte(t1);
        end
        plan_byte(CH_CR);
        plan_byte(CH_LF);
    endtask

    task automatic plan_noise();
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0:
                plan_line("");
            1:
            begin
                plan_byte(hex_char(4'($urandom_range(1, 15))));
                repeat ($urandom_range(8, 10))
                    plan_byte(hex_char(4'($urandom_range(0, 15))));
                plan_byte(CH_CR);
                plan_byte(CH_LF);
            end
            default:
            begin
                // Random bytes with no hex digit, so no line here can carry a size.
                repeat ($urandom_range(1, 8))
                begin
                    b = 8'($urandom_range(0, 255));
                    if (hex_digit(b) >= 5'd16)
                        b = CH_NOT_HEX;
                    plan_byte(b);
                end
                if (plan_state.pending_cr)
                    plan_byte(CH_LF);
                else if (plan_state.line_has_chars)
                begin
                    plan_byte(CH_CR);
                    plan_byte(CH_LF);
                end
            end
        endcase
    endtask

    task automatic wait_sent();
        @(negedge clk);
        while (pending_bytes.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (pending_bytes.size() != 0 && !hold_sender && !sender_idles())
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_bytes[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= !receiver_stalls();
        end
    end

    always @(posedge clk)
    begin
        decoded_t got;
        decoded_t want;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(decoder_now, s_axis_tdata, got);
                expected_results.push_back(got);
                void'(pending_bytes.pop_front());
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("output transfer with nothing expected: event_res %0d", m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.event_res)
                    begin
                        $error("event_res: expected %0d, actual %0d", want.event_res, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata !== want.data_byte)
                    begin
                        $error("data_byte: expected %02h, actual %02h", want.data_byte, m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.chunk_last)
                    begin
                        $error("chunk_last: expected %0d, actual %0d", want.chunk_last, m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int phase_start;
        decoder_now.phase = PH_SIZE;
        plan_state.phase = PH_SIZE;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan_line("");
        plan_byte(CH_CR);
        plan_line("1");
        plan_line(";");
        plan_line("2;");
        plan_byte(8'h00);
        plan_byte(8'hFF);
        plan_byte("x");
        plan_byte("y");
        plan_byte(CH_CR);
        plan_byte(CH_LF);
        plan_line("1");
        plan_byte(CH_CR);
        plan_byte(CH_CR);
        plan_byte("Z");
        plan_byte(CH_CR);
        plan_byte(CH_LF);
        wait_sent();

        // The first random phase is held back until every result of the directed part is out.
        hold_sender = 1'b1;
        for (int m = 0; m < 4; m++)
        begin
            idle_mode = idle_mode_t'(m);
            phase_start = planned_count;
            while (planned_count - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(0, 4) == 0)
                    plan_noise();
                else
                    plan_chunk();
            end
            if (hold_sender)
            begin
                wait_drained();
                hold_sender = 1'b0;
            end
            wait_sent();
        end

        // The zero-size line ends the body; the bytes after it must all be absorbed.
        plan_line("0");
        plan_byte(8'h00);
        plan_byte(8'hFF);
        plan_byte(CH_CR);
        plan_byte(CH_LF);
        plan_byte("7");
        wait_sent();
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
